// ===== rtl/kris_pkg.sv =====
`timescale 1ns / 1ps
// Package for the k-resource interval scheduler: payload structs, cell control
// structs, FSM state type and fixed field widths. No dependencies.
package kris_pkg;

  localparam int TIME_W = 16;
  localparam int CNT_W  = 8;
  localparam int CFG_W  = 4;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic              last_item;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] accepted_count;
    logic             overflow;
  } out_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } span_t;

  // Control broadcast to every cell of the sort chain.
  typedef struct packed {
    logic  ins;
    logic  drain;
    span_t item;
  } sort_ctl_t;

  // Control broadcast to every cell of the resource chain.
  typedef struct packed {
    logic              clear;
    logic              step;
    logic [TIME_W-1:0] start_time;
  } res_ctl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_DONE
  } st_t;

endpackage

// ===== rtl/kris_sort_cell.sv =====
`timescale 1ns / 1ps
// One cell of the insertion sort chain: holds one interval, ordered by end time.
// Depends on kris_pkg.
module kris_sort_cell (
  input  logic               clk,
  input  kris_pkg::sort_ctl_t ctl,
  input  logic               occ,
  input  logic               prev_gt,
  input  kris_pkg::span_t    prev_span,
  input  kris_pkg::span_t    next_span,
  output kris_pkg::span_t    span_q,
  output logic               gt
);

  kris_pkg::span_t span_r;
  kris_pkg::span_t span_nxt;

  // Empty cells and cells with a strictly later end make room; equal ends stay
  // ahead of the newcomer, which keeps the sort stable.
  assign gt = !occ || (span_r.end_time > ctl.item.end_time);

  always_comb begin
    span_nxt = span_r;
    if (ctl.ins && gt) begin
      span_nxt = prev_gt ? prev_span : ctl.item;
    end else if (ctl.drain) begin
      span_nxt = next_span;
    end
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
  end

  assign span_q = span_r;

endmodule

// ===== rtl/kris_res_cell.sv =====
`timescale 1ns / 1ps
// One cell of the resource chain: holds one resource end time. The chain is
// kept in descending order. Depends on kris_pkg.
module kris_res_cell (
  input  logic                        clk,
  input  kris_pkg::res_ctl_t          ctl,
  input  logic                        active,
  input  logic                        any_hit,
  input  logic                        prev_hit,
  input  logic [kris_pkg::TIME_W-1:0] prev_val,
  output logic [kris_pkg::TIME_W-1:0] val_q,
  output logic                        hit
);

  logic [kris_pkg::TIME_W-1:0] val_r;
  logic [kris_pkg::TIME_W-1:0] val_nxt;
  logic                        shift;

  assign hit = active && (val_r <= ctl.start_time);

  // Cells up to and including the first fitting one move down by one; the
  // freed front slot takes the new end time.
  assign shift = ctl.step && any_hit && active && !prev_hit;

  always_comb begin
    val_nxt = val_r;
    if (ctl.clear) begin
      val_nxt = '0;
    end else if (shift) begin
      val_nxt = prev_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_q = val_r;

endmodule

// ===== rtl/k_resource_interval_scheduler.sv =====
`timescale 1ns / 1ps
// Greedy interval scheduler on up to MAX_PEOPLE resources. Intervals load one
// per cycle into a chain of MAX_ITEMS sort cells that keeps them in stable
// end-time order as they arrive; an interval arriving with the chain full is
// dropped and flagged. After the transaction marked last_item, the chain
// shifts its N stored intervals out one per cycle into a chain of resource
// cells that holds the resource end times in descending order, so the best
// fit (latest end not after the start) is the first cell that fits. Once a
// set is drained its result is posted to the output register; posting
// waits as long as the previous result is still held in that register.
// Dropped intervals are still taken at the input.
// The input is not ready during drain and result posting.
// Depends on kris_pkg, kris_sort_cell, kris_res_cell.
module k_resource_interval_scheduler #(
  parameter int MAX_ITEMS  = 128,
  parameter int MAX_PEOPLE = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  kris_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output kris_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kris_pkg::CFG_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_ITEMS + 1);

  kris_pkg::st_t state_r, state_nxt;

  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              remain_r, remain_nxt;
  logic                       ovf_seen_r, ovf_seen_nxt;
  logic                       res_ovf_r, res_ovf_nxt;
  logic [kris_pkg::CNT_W-1:0] accepted_r, accepted_nxt;
  logic [kris_pkg::CFG_W-1:0] num_people_r;
  logic                       out_valid_r, out_valid_nxt;
  kris_pkg::out_item_t        out_data_r, out_data_nxt;

  logic in_acc;
  logic has_room;
  logic close_set;
  logic drain_en;
  logic post_en;
  logic any_hit;

  kris_pkg::sort_ctl_t sort_ctl;
  kris_pkg::res_ctl_t  res_ctl;
  kris_pkg::span_t     cell_q [MAX_ITEMS];
  logic                cell_gt [MAX_ITEMS];
  logic [kris_pkg::TIME_W-1:0] res_q [MAX_PEOPLE];
  logic [MAX_PEOPLE-1:0]       res_hit;

  // Output decode per state.
  always_comb begin
    in_ready = 1'b0;
    drain_en = 1'b0;
    post_en  = 1'b0;
    case (state_r)
      kris_pkg::ST_LOAD:  in_ready = 1'b1;
      kris_pkg::ST_DRAIN: drain_en = 1'b1;
      kris_pkg::ST_DONE:  post_en  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign has_room  = (count_r != CW'(MAX_ITEMS));
  assign close_set = in_acc && in_data.last_item;
  assign any_hit   = |res_hit;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kris_pkg::ST_LOAD:  if (close_set) state_nxt = kris_pkg::ST_DRAIN;
      kris_pkg::ST_DRAIN: if (remain_r <= CW'(1)) state_nxt = kris_pkg::ST_DONE;
      kris_pkg::ST_DONE:  if (post_en) state_nxt = kris_pkg::ST_LOAD;
      default:            state_nxt = kris_pkg::ST_LOAD;
    endcase
  end

  // Sort chain control: insert on a stored transaction, shift toward the head
  // while draining.
  always_comb begin
    sort_ctl.ins        = in_acc && has_room;
    sort_ctl.drain      = drain_en;
    sort_ctl.item.start_time = in_data.start_time;
    sort_ctl.item.end_time   = in_data.end_time;
  end

  // Resource chain control: clear when a set closes, one best-fit step per
  // drained interval using the chain head.
  always_comb begin
    res_ctl.clear      = close_set;
    res_ctl.step       = drain_en;
    res_ctl.start_time = cell_q[0].start_time;
  end

  // Bookkeeping for counts, flags and the result register.
  always_comb begin
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    ovf_seen_nxt  = ovf_seen_r;
    res_ovf_nxt   = res_ovf_r;
    accepted_nxt  = accepted_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      // Store or drop the incoming interval.
      if (has_room) begin
        count_nxt = count_r + CW'(1);
      end else begin
        ovf_seen_nxt = 1'b1;
      end
      if (in_data.last_item) begin
        // Hand the set to the drain phase and open a fresh one.
        remain_nxt   = has_room ? count_r + CW'(1) : count_r;
        res_ovf_nxt  = ovf_seen_r || !has_room;
        accepted_nxt = '0;
        count_nxt    = '0;
        ovf_seen_nxt = 1'b0;
      end
    end

    if (drain_en) begin
      // Advance one interval; count it if some resource took it.
      remain_nxt = remain_r - CW'(1);
      if (any_hit) begin
        accepted_nxt = accepted_r + kris_pkg::CNT_W'(1);
      end
    end

    if (post_en) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.accepted_count = accepted_r;
      out_data_nxt.overflow       = res_ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kris_pkg::ST_LOAD;
      count_r      <= '0;
      remain_r     <= '0;
      ovf_seen_r   <= 1'b0;
      res_ovf_r    <= 1'b0;
      accepted_r   <= '0;
      out_valid_r  <= 1'b0;
      num_people_r <= kris_pkg::CFG_W'(1);
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      ovf_seen_r  <= ovf_seen_nxt;
      res_ovf_r   <= res_ovf_nxt;
      accepted_r  <= accepted_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        num_people_r <= cfg_data;
      end
    end
  end

  // Payload register: no reset.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sort chain: cell 0 is the head (earliest end time).
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_sort
    kris_pkg::span_t prev_span;
    kris_pkg::span_t next_span;
    logic            prev_gt;

    if (i == 0) begin : g_head
      assign prev_span = sort_ctl.item;
      assign prev_gt   = 1'b0;
    end else begin : g_body
      assign prev_span = cell_q[i-1];
      assign prev_gt   = cell_gt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_tail
      assign next_span = cell_q[i];
    end else begin : g_mid
      assign next_span = cell_q[i+1];
    end

    kris_sort_cell u_cell (
      .clk       (clk),
      .ctl       (sort_ctl),
      .occ       (count_r > CW'(i)),
      .prev_gt   (prev_gt),
      .prev_span (prev_span),
      .next_span (next_span),
      .span_q    (cell_q[i]),
      .gt        (cell_gt[i])
    );
  end

  // Resource chain: only the first num_people cells take part.
  for (genvar p = 0; p < MAX_PEOPLE; p++) begin : g_res
    logic [kris_pkg::TIME_W-1:0] prev_val;
    logic                        prev_hit;

    if (p == 0) begin : g_head
      assign prev_val = cell_q[0].end_time;
      assign prev_hit = 1'b0;
    end else begin : g_body
      assign prev_val = res_q[p-1];
      assign prev_hit = res_hit[p-1];
    end

    kris_res_cell u_cell (
      .clk      (clk),
      .ctl      (res_ctl),
      .active   (32'(num_people_r) > p),
      .any_hit  (any_hit),
      .prev_hit (prev_hit),
      .prev_val (prev_val),
      .val_q    (res_q[p]),
      .hit      (res_hit[p])
    );
  end

endmodule

// ===== rtl/kris_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the interval scheduler, bound to the top level.
// Depends on kris_pkg and k_resource_interval_scheduler.
module kris_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input kris_pkg::in_item_t         in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input kris_pkg::out_item_t        out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Closing a set stops intake while it drains.
  a_close_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_item |=> !in_ready)
    else $error("input taken right after closing a set");

  // A new result only follows a cycle without intake.
  a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result posted while loading");

  // Reset drops any pending result.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind k_resource_interval_scheduler kris_checker u_kris_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== dv/k_resource_interval_scheduler_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for k_resource_interval_scheduler: a directed table, then random interval
// sets under three idling profiles, scored against a best-fit scheduling predictor or typed values.
// Depends on kris_pkg and the scheduler RTL.
module k_resource_interval_scheduler_tb;

  localparam int MAX_ITEMS   = 128;
  localparam int MAX_PEOPLE  = 8;
  // Idle time after the last result before touching the register: a full drain plus posting.
  localparam int DRAIN_WAIT  = MAX_ITEMS + 4;
  // Cycles without any transaction before the run is declared hung.
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int SEG_ITEMS   = 100;

  // Per-item tag: a row with a hand-typed result carries it here.
  typedef struct packed {
    logic                typed;
    kris_pkg::out_item_t want;
  } item_tag_t;

  // One row of the directed table: either a register write or one interval.
  typedef struct packed {
    logic                       cfg_row;
    logic [kris_pkg::CFG_W-1:0] cfg_val;
    kris_pkg::in_item_t         item;
    item_tag_t                  tag;
  } plan_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  kris_pkg::in_item_t         in_data;
  logic                       out_valid;
  logic                       out_ready;
  kris_pkg::out_item_t        out_data;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [kris_pkg::CFG_W-1:0] cfg_data;

  // Predictor state: the open set, its drop flag and the resource count.
  kris_pkg::span_t            held [MAX_ITEMS];
  int                         held_n  = 0;
  bit                         dropped = 1'b0;
  logic [kris_pkg::CFG_W-1:0] people  = kris_pkg::CFG_W'(1);

  item_tag_t           item_tags [$];
  kris_pkg::out_item_t due_results [$];
  plan_row_t           plan [$];

  int unsigned      send_idle_pct = 0;
  int unsigned      recv_idle_pct = 0;
  bit               hold_req = 1'b0;
  int               fail_count = 0;
  int               quiet_cycles = 0;

  k_resource_interval_scheduler #(
    .MAX_ITEMS (MAX_ITEMS),
    .MAX_PEOPLE(MAX_PEOPLE)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sort the open set stably by end time, then hand each interval to the resource
  // with the latest end time not after its start (lowest index wins a tie).
  function automatic logic [kris_pkg::CNT_W-1:0] count_scheduled();
    kris_pkg::span_t             order [MAX_ITEMS];
    logic [kris_pkg::TIME_W-1:0] busy_until [MAX_PEOPLE];
    kris_pkg::span_t             cur;
    int                          k, i, j, p, best, accepted;
    bit                          found;
    k = (people > MAX_PEOPLE) ? MAX_PEOPLE : int'(people);
    accepted = 0;
    for (p = 0; p < MAX_PEOPLE; p++) busy_until[p] = '0;
    for (i = 0; i < held_n; i++) order[i] = held[i];
    for (i = 1; i < held_n; i++) begin
      cur = order[i];
      j = i;
      while (j > 0 && order[j-1].end_time > cur.end_time) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (i = 0; i < held_n; i++) begin
      found = 1'b0;
      best  = 0;
      for (p = 0; p < k; p++) begin
        if (busy_until[p] <= order[i].start_time &&
            (!found || busy_until[p] > busy_until[best])) begin
          best  = p;
          found = 1'b1;
        end
      end
      if (found) begin
        busy_until[best] = order[i].end_time;
        accepted++;
      end
    end
    return accepted[kris_pkg::CNT_W-1:0];
  endfunction

  // Take one accepted interval into the open set; on the closing one, queue the result.
  function automatic void absorb_interval(input kris_pkg::in_item_t it, input item_tag_t tag);
    kris_pkg::out_item_t r;
    if (held_n < MAX_ITEMS) begin
      held[held_n].start_time = it.start_time;
      held[held_n].end_time   = it.end_time;
      held_n++;
    end else begin
      dropped = 1'b1;
    end
    if (it.last_item) begin
      r.accepted_count = count_scheduled();
      r.overflow       = dropped;
      // A hand-typed row is scored against its typed value.
      due_results.push_back(tag.typed ? tag.want : r);
      held_n  = 0;
      dropped = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample every handshake at the rising edge, score results, watch for hangs
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    item_tag_t           tag;
    kris_pkg::out_item_t want;
    bit                  moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        people = cfg_data;
        moved  = 1'b1;
      end
      if (in_valid && in_ready) begin
        tag = item_tags.pop_front();
        absorb_interval(in_data, tag);
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (due_results.size() == 0) begin
          report_mismatch("result with nothing expected", int'(out_data.accepted_count), -1);
        end else begin
          want = due_results.pop_front();
          if (out_data.accepted_count !== want.accepted_count)
            report_mismatch("accepted_count", int'(out_data.accepted_count),
                            int'(want.accepted_count));
          if (out_data.overflow !== want.overflow)
            report_mismatch("overflow", int'(out_data.overflow), int'(want.overflow));
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("k_resource_interval_scheduler: mismatch");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random back-pressure, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int hold_left;
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // Hold ready low so the block fills up and stalls its input.
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one interval from a falling edge; return at the edge that accepts it.
  // Valid stays high into the next call, so back-to-back transactions have no bubble.
  task automatic offer_interval(input kris_pkg::in_item_t it, input item_tag_t tag);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    item_tags.push_back(tag);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait for every expected result, then let a full drain time pass.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_people(input logic [kris_pkg::CFG_W-1:0] v);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly dense short intervals so resources contend; some full-range and reversed ones.
  function automatic kris_pkg::in_item_t random_interval(input bit last);
    kris_pkg::in_item_t it;
    int unsigned        style;
    style = $urandom_range(9);
    if (style < 3) begin
      it.start_time = kris_pkg::TIME_W'($urandom_range(65535));
      it.end_time   = kris_pkg::TIME_W'($urandom_range(65535));
    end else if (style < 9) begin
      it.start_time = kris_pkg::TIME_W'($urandom_range(511));
      it.end_time   = kris_pkg::TIME_W'(it.start_time + $urandom_range(80));
    end else begin
      it.start_time = kris_pkg::TIME_W'($urandom_range(600));
      it.end_time   = kris_pkg::TIME_W'($urandom_range(it.start_time));
    end
    it.last_item = last;
    return it;
  endfunction

  task automatic send_random_set(input int n);
    int i;
    for (i = 0; i < n; i++) offer_interval(random_interval(i == n - 1), '0);
  endtask

  // Mostly small sets; a few large ones and a few past capacity.
  function automatic int pick_set_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2) return MAX_ITEMS + 1 + int'($urandom_range(7));
    if (roll < 8) return int'($urandom_range(MAX_ITEMS, 16));
    return int'($urandom_range(12, 1));
  endfunction

  function automatic plan_row_t item_row(input int s, input int e, input bit last,
                                         input bit typed = 1'b0, input int cnt = 0,
                                         input bit ovf = 1'b0);
    plan_row_t r;
    r = '0;
    r.item.start_time         = s[kris_pkg::TIME_W-1:0];
    r.item.end_time           = e[kris_pkg::TIME_W-1:0];
    r.item.last_item          = last;
    r.tag.typed               = typed;
    r.tag.want.accepted_count = cnt[kris_pkg::CNT_W-1:0];
    r.tag.want.overflow       = ovf;
    return r;
  endfunction

  function automatic plan_row_t people_row(input int v);
    plan_row_t r;
    r = '0;
    r.cfg_row = 1'b1;
    r.cfg_val = v[kris_pkg::CFG_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int                         ph, seg, sent, n, i;
    logic [kris_pkg::CFG_W-1:0] v;
    kris_pkg::in_item_t         it;
    item_tag_t                  tag;
    int unsigned                people_plan [12];

    people_plan = '{1, 8, 0, 4, 15, 2, 3, 6, 8, 1, 5, 3};
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // First profile: sender idles a quarter of the time, receiver most of it.
    send_idle_pct = 25;
    recv_idle_pct = 84;

    // Directed table; the resource count starts at its reset value of one.
    plan.push_back(item_row(0, 0, 1, 1, 1, 0));             // zero-length at time zero
    plan.push_back(item_row(65535, 65535, 1, 1, 1, 0));     // top of the time range
    plan.push_back(item_row(65535, 0, 1, 1, 1, 0));         // end before start
    plan.push_back(item_row(0, 10, 0));
    plan.push_back(item_row(5, 20, 1));                     // overlap on one resource
    plan.push_back(people_row(0));                          // no resource at all
    plan.push_back(item_row(0, 5, 0));
    plan.push_back(item_row(10, 20, 1, 1, 0, 0));
    plan.push_back(people_row(15));                         // saturates to the maximum
    plan.push_back(item_row(0, 100, 0));
    plan.push_back(item_row(0, 100, 0));
    plan.push_back(item_row(0, 100, 1, 1, 3, 0));
    plan.push_back(people_row(2));
    // Arrival order differs from end order; best fit accepts the last, first fit would not.
    plan.push_back(item_row(0, 10, 0));
    plan.push_back(item_row(0, 5, 0));
    plan.push_back(item_row(12, 20, 0));
    plan.push_back(item_row(7, 25, 1));
    // Equal end times keep arrival order.
    plan.push_back(item_row(5, 30, 0));
    plan.push_back(item_row(0, 30, 0));
    plan.push_back(item_row(0, 40, 1));
    plan.push_back(people_row(8));
    plan.push_back(item_row(0, 65535, 0));
    plan.push_back(item_row(0, 65535, 1, 1, 2, 0));

    foreach (plan[row]) begin
      if (plan[row].cfg_row) write_people(plan[row].cfg_val);
      else offer_interval(plan[row].item, plan[row].tag);
    end

    // Store full: one past capacity, all fitting one resource, gives the top count.
    write_people(kris_pkg::CFG_W'(1));
    tag.typed = 1'b1;
    tag.want.accepted_count = kris_pkg::CNT_W'(MAX_ITEMS);
    tag.want.overflow = 1'b1;
    for (i = 0; i <= MAX_ITEMS; i++) begin
      it = '0;
      it.last_item = (i == MAX_ITEMS);
      offer_interval(it, (i == MAX_ITEMS) ? tag : item_tag_t'('0));
    end
    // Store full with the closing interval itself dropped.
    send_random_set(MAX_ITEMS + 2);

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 25;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 25;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (seg = 0; seg < 4; seg++) begin
        v = (seg == 3) ? kris_pkg::CFG_W'($urandom_range(15)) :
                         kris_pkg::CFG_W'(people_plan[ph*4 + seg]);
        write_people(v);
        if (ph == 2 && seg == 0) begin
          // Hold the receiver off while small sets keep coming.
          hold_req = 1'b1;
          for (i = 0; i < 8; i++) send_random_set(4);
        end
        sent = 0;
        while (sent < SEG_ITEMS) begin
          n = pick_set_size();
          send_random_set(n);
          sent += n;
        end
      end
    end

    quiesce();
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("k_resource_interval_scheduler: match");
    end else begin
      $display("k_resource_interval_scheduler: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/kris_pkg.sv
rtl/kris_sort_cell.sv
rtl/kris_res_cell.sv
rtl/k_resource_interval_scheduler.sv
rtl/kris_checker.sv
dv/k_resource_interval_scheduler_tb.sv
